FILE: sv/md5lz_pkg.sv
// Package for the MD5 leading-zero nonce check: constants, round tables, helpers.
// No dependencies.
package md5lz_pkg;

    localparam int unsigned CandW       = 31;
    localparam int unsigned DiffW       = 6;
    localparam int unsigned DefMaxDigits = 10;
    localparam logic [DiffW-1:0] ResetDifficulty = 6'd6;
    localparam logic [DiffW-1:0] HexDigits = 6'd32;
    localparam int unsigned BcdW        = 40;   // 10 BCD digits cover 31 bits
    localparam int unsigned NumBcd      = 10;

    localparam logic [31:0] IvA = 32'h67452301;
    localparam logic [31:0] IvB = 32'hefcdab89;
    localparam logic [31:0] IvC = 32'h98badcfe;
    localparam logic [31:0] IvD = 32'h10325476;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_block;

    localparam t_word MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [4:0] md5_shift(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'b0000: s = 5'd7;  4'b0001: s = 5'd12;
                4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
                4'b0100: s = 5'd5;  4'b0101: s = 5'd9;
                4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
                4'b1000: s = 5'd4;  4'b1001: s = 5'd11;
                4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
                4'b1100: s = 5'd6;  4'b1101: s = 5'd10;
                4'b1110: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] md5_msg_ix(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0:    g = i[3:0];
                2'd1:    g = 4'(5 * i[3:0] + 1);
                2'd2:    g = 4'(3 * i[3:0] + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction

    // One MD5 round on state {a,b,c,d}; returns the rotated state {a,b,c,d}.
    function automatic logic [127:0] md5_round(input logic [5:0] i, input t_word a,
                                               input t_word b, input t_word c,
                                               input t_word d, input t_word m);
        t_word f;
        t_word t;
        t_word r;
        logic [4:0] s;
        begin
            case (i[5:4])
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (d & b) | (~d & c);
                2'd2:    f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            t = a + f + MD5_K[i] + m;
            s = md5_shift(i);
            r = (t << s) | (t >> (6'd32 - {1'b0, s}));
            return {d, b + r, b, c};
        end
    endfunction

    // Double dabble step: add 3 to every BCD digit at 5 or above.
    function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] v);
        logic [BcdW-1:0] o;
        begin
            o = v;
            for (int k = 0; k < NumBcd; k++) begin
                if (v[4*k +: 4] >= 4'd5) o[4*k +: 4] = v[4*k +: 4] + 4'd3;
            end
            return o;
        end
    endfunction

endpackage

FILE: sv/md5_leading_zero_nonce_check.sv
// Throughput: one item per cycle while not stalled; the 64 MD5 rounds are one register stage each,
// preceded by a 31-bit binary to BCD conversion over 4 stages (up to 8 bits a stage).
// Reset (synchronous, active low) clears all valid bits and sets difficulty to 6.
// A global stall holds every stage while the output register is full and not taken.
// Top level; depends on md5lz_pkg.
module md5_leading_zero_nonce_check
    import md5lz_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = DefMaxDigits
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CandW-1:0]  i_candidate,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CandW-1:0]  o_found_nonce,
    input  logic              i_cfg_we,
    input  logic [DiffW-1:0]  i_cfg_difficulty_digits
);

    localparam int unsigned BcdStages = 4;
    localparam int unsigned Rounds    = 64;

    logic [DiffW-1:0] r_diff;
    logic             adv;

    // Whole pipe advances unless the output holds an untaken result.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= ResetDifficulty;
        end else if (i_cfg_we) begin
            r_diff <= i_cfg_difficulty_digits;
        end
    end

    // ---------------- BCD conversion: shift-and-add-3, up to 8 bits per stage
    logic [BcdStages:0]       r_bv;
    logic [CandW-1:0]         r_bcand [BcdStages+1];
    logic [CandW-1:0]         r_bsh   [BcdStages+1];
    logic [BcdW-1:0]          r_bcd   [BcdStages+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (adv) begin
            r_bv <= {r_bv[BcdStages-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bcand[0] <= i_candidate;
            r_bsh[0]   <= i_candidate;
            r_bcd[0]   <= '0;
        end
    end

    for (genvar s = 0; s < BcdStages; s++) begin : g_bcd
        logic [BcdW-1:0]  n_bcd;
        logic [CandW-1:0] n_sh;
        always_comb begin
            n_bcd = r_bcd[s];
            n_sh  = r_bsh[s];
            for (int k = 0; k < 8; k++) begin
                if (s * 8 + k < CandW) begin
                    n_bcd = bcd_adjust(n_bcd);
                    n_bcd = {n_bcd[BcdW-2:0], n_sh[CandW-1]};
                    n_sh  = {n_sh[CandW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_bcand[s+1] <= r_bcand[s];
                r_bsh[s+1]   <= n_sh;
                r_bcd[s+1]   <= n_bcd;
            end
        end
    end

    // ---------------- Message block build
    t_block            n_blk;
    logic              n_long;
    logic [4:0]        n_len;
    logic [BcdW-1:0]   bcd_fin;

    assign bcd_fin = r_bcd[BcdStages];

    always_comb begin
        logic [7:0] bytes [64];
        n_len = 5'd1;
        for (int k = 0; k < NumBcd; k++) begin
            if (bcd_fin[4*k +: 4] != 4'd0) n_len = 5'(k + 1);
        end
        n_long = ({27'd0, n_len} > 32'(MAX_DIGITS));
        for (int j = 0; j < 64; j++) bytes[j] = 8'h00;
        for (int j = 0; j < NumBcd; j++) begin
            if (5'(j) < n_len) bytes[j] = {4'h3, bcd_fin[4*(n_len-5'd1-5'(j)) +: 4]};
            else if (5'(j) == n_len) bytes[j] = 8'h80;
        end
        if (n_len == 5'(NumBcd)) bytes[NumBcd] = 8'h80;
        bytes[56] = {n_len, 3'b000};
        for (int w = 0; w < 16; w++)
            n_blk[w] = {bytes[4*w+3], bytes[4*w+2], bytes[4*w+1], bytes[4*w]};
    end

    // ---------------- 64 round stages
    logic [Rounds:0]  r_rv;
    logic [Rounds:0]  r_rlong;
    logic [CandW-1:0] r_rcand [Rounds+1];
    t_block           r_msg   [Rounds+1];
    logic [127:0]     r_st    [Rounds+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (adv) begin
            r_rv <= {r_rv[Rounds-1:0], r_bv[BcdStages]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rcand[0] <= r_bcand[BcdStages];
            r_msg[0]   <= n_blk;
            r_rlong[0] <= n_long;
            r_st[0]    <= {IvA, IvB, IvC, IvD};
        end
    end

    for (genvar i = 0; i < Rounds; i++) begin : g_rnd
        logic [127:0] n_st;
        assign n_st = md5_round(6'(i), r_st[i][127:96], r_st[i][95:64], r_st[i][63:32],
                                r_st[i][31:0], r_msg[i][md5_msg_ix(6'(i))]);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[i+1]    <= n_st;
                r_msg[i+1]   <= r_msg[i];
                r_rcand[i+1] <= r_rcand[i];
                r_rlong[i+1] <= r_rlong[i];
            end
        end
    end

    // ---------------- Final add and leading zero test
    logic [127:0] n_dig;
    logic         r_fv;
    logic [127:0] r_dig;
    logic [CandW-1:0] r_fcand;
    logic         r_flong;

    assign n_dig = {r_st[Rounds][127:96] + IvA, r_st[Rounds][95:64] + IvB,
                    r_st[Rounds][63:32] + IvC, r_st[Rounds][31:0] + IvD};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (adv) begin
            r_fv <= r_rv[Rounds];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dig   <= n_dig;
            r_fcand <= r_rcand[Rounds];
            r_flong <= r_rlong[Rounds];
        end
    end

    logic hit;
    always_comb begin
        logic [31:0] h;
        logic [3:0]  nib;
        hit = !r_flong && (r_diff <= HexDigits);
        for (int d = 0; d < 32; d++) begin
            h   = r_dig[127 - 32*(d/8) -: 32];
            nib = h[8*((d/2)%4) + 4*(1-(d%2)) +: 4];
            if (6'(d) < r_diff && nib != 4'd0) hit = 1'b0;
        end
    end

    // Output register: drop misses, hold a hit until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_fv && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) o_found_nonce <= r_fcand;
    end

endmodule

FILE: sv/md5lz_checker.sv
// Port-level assertions for the nonce check, bound to the top level.
// Depends on md5lz_pkg.
module md5lz_sva
    import md5lz_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [CandW-1:0] o_found_nonce
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found_nonce))
        else $error("result dropped or changed while stalled");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind md5_leading_zero_nonce_check md5lz_sva u_md5lz_sva (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_found_nonce(o_found_nonce)
);
